FILE: rtl/lwic_pkg.sv
package lwic_pkg;

    // Stack geometry.
    localparam int DEPTH       = 64;
    localparam int HANDLE_BITS = 32;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    // The cursor runs from -1 (before the first entry) to DEPTH (past the last).
    localparam int CUR_W       = ADDR_W + 2;

    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_NEXT   = 3'd3,
        OP_REWIND = 3'd4,
        OP_SETDIR = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic load;
    } t_cmd;

endpackage

FILE: rtl/lwic_in_if.sv
interface lwic_in_if;
    logic                                valid;
    logic                                ready;
    lwic_pkg::t_op                       op;
    logic [lwic_pkg::HANDLE_BITS-1:0]    handle_in;
    logic                                new_direction;

    modport source (output valid, output op, output handle_in, output new_direction,
                    input ready);
    modport sink   (input valid, input op, input handle_in, input new_direction,
                    output ready);
endinterface

FILE: rtl/lwic_out_if.sv
interface lwic_out_if;
    logic                                valid;
    logic                                ready;
    logic [lwic_pkg::HANDLE_BITS-1:0]    handle_out;
    logic                                found;
    logic [lwic_pkg::ADDR_W-1:0]         push_index;
    logic [lwic_pkg::CNT_W-1:0]          entry_count;
    lwic_pkg::t_status                   status;

    modport source (output valid, output handle_out, output found, output push_index,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input handle_out, input found, input push_index,
                    input entry_count, input status, output ready);
endinterface

FILE: rtl/lifo_with_iterator_cursor.sv
// A result word enters the output register in the controller's load step, after its word
// is accepted and once that register is free; no new word is taken before then.
// A new word is taken while the previous result still waits to be read out.
// Reset (synchronous, active low) empties the stack, sets the cursor to 0 and selects
// backward iteration; the entry RAM is not cleared and needs no clearing pass.
module lifo_with_iterator_cursor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lwic_in_if.sink     i_in,
    lwic_out_if.source  o_out
);
    import lwic_pkg::*;

    t_cmd w_cmd;

    // The controller sequences each word through two steps. In the first, the
    // datapath decides the whole outcome from the stack count, the cursor and
    // the direction, updates them, writes the RAM for a push and starts the RAM
    // read for a pop or a next. In the second, the read data is joined to the
    // settled fields and the result word is moved into the output register, as
    // soon as that register is empty or is being emptied in the same cycle.
    lwic_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the count, the signed cursor (from before the first
    // entry to past the last), the direction and the entry RAM. Popping leaves
    // the cursor where it was, so a backward next may return an entry already
    // popped; the RAM still holds its last written value.
    lwic_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_op            (i_in.op),
        .i_handle_in     (i_in.handle_in),
        .i_new_direction (i_in.new_direction),
        .o_handle_out    (o_out.handle_out),
        .o_found         (o_out.found),
        .o_push_index    (o_out.push_index),
        .o_entry_count   (o_out.entry_count),
        .o_status        (o_out.status)
    );

endmodule

FILE: rtl/lwic_ram.sv
module lwic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/lwic_dp.sv
module lwic_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lwic_pkg::t_cmd                      i_cmd,
    input  lwic_pkg::t_op                       i_op,
    input  logic [lwic_pkg::HANDLE_BITS-1:0]    i_handle_in,
    input  logic                                i_new_direction,
    output logic [lwic_pkg::HANDLE_BITS-1:0]    o_handle_out,
    output logic                                o_found,
    output logic [lwic_pkg::ADDR_W-1:0]         o_push_index,
    output logic [lwic_pkg::CNT_W-1:0]          o_entry_count,
    output lwic_pkg::t_status                   o_status
);
    import lwic_pkg::*;

    // Architectural state.
    logic [CNT_W-1:0]        r_count,    n_count;
    logic signed [CUR_W-1:0] r_cursor,   n_cursor;
    logic                    r_backward, n_backward;

    // Result fields settled at acceptance, waiting for the read data.
    logic                    r_res_found,  n_res_found;
    logic [ADDR_W-1:0]       r_res_pidx,   n_res_pidx;
    t_status                 r_res_status, n_res_status;

    // Output register.
    logic [HANDLE_BITS-1:0]  r_out_handle;
    logic                    r_out_found;
    logic [ADDR_W-1:0]       r_out_pidx;
    logic [CNT_W-1:0]        r_out_count;
    t_status                 r_out_status;

    logic                    w_we;
    logic                    w_re;
    logic [ADDR_W-1:0]       w_raddr;
    logic [HANDLE_BITS-1:0]  w_rdata;
    logic signed [CUR_W-1:0] w_count_s;
    logic signed [CUR_W-1:0] w_cur_inc;
    logic signed [CUR_W-1:0] w_cur_dec;
    logic signed [CUR_W-1:0] w_start;

    assign w_count_s = $signed({{(CUR_W-CNT_W){1'b0}}, r_count});
    assign w_cur_inc = r_cursor + CUR_W'(1);
    assign w_cur_dec = r_cursor - CUR_W'(1);
    assign w_start   = r_backward ? w_count_s : '1;

    always_comb begin
        n_count      = r_count;
        n_cursor     = r_cursor;
        n_backward   = r_backward;
        n_res_found  = 1'b0;
        n_res_pidx   = '0;
        n_res_status = ST_OK;
        w_we         = 1'b0;
        w_re         = 1'b0;
        w_raddr      = '0;
        case (i_op)
            OP_PUSH: begin
                if (r_count >= CNT_W'(DEPTH)) begin
                    n_res_status = ST_FULL;
                end else begin
                    w_we       = i_cmd.accept;
                    n_res_pidx = r_count[ADDR_W-1:0];
                    n_count    = r_count + CNT_W'(1);
                    // First entry: cursor goes to the starting end.
                    if (r_count == '0) begin
                        n_cursor = r_backward ? CUR_W'(1) : '1;
                    end
                end
            end
            OP_POP: begin
                if (r_count != '0) begin
                    n_count     = r_count - CNT_W'(1);
                    w_re        = i_cmd.accept;
                    w_raddr     = n_count[ADDR_W-1:0];
                    n_res_found = 1'b1;
                end else begin
                    n_res_status = ST_NONE;
                end
            end
            OP_CLEAR: begin
                n_count  = '0;
                n_cursor = '0;
            end
            OP_NEXT: begin
                if (r_count == '0) begin
                    n_res_status = ST_NONE;
                end else if (!r_backward) begin
                    if (r_cursor < w_count_s - CUR_W'(1)) begin
                        n_cursor    = w_cur_inc;
                        w_re        = i_cmd.accept;
                        w_raddr     = w_cur_inc[ADDR_W-1:0];
                        n_res_found = 1'b1;
                    end else begin
                        n_res_status = ST_NONE;
                    end
                end else begin
                    if (r_cursor > CUR_W'(0)) begin
                        n_cursor    = w_cur_dec;
                        w_re        = i_cmd.accept;
                        w_raddr     = w_cur_dec[ADDR_W-1:0];
                        n_res_found = 1'b1;
                    end else begin
                        n_res_status = ST_NONE;
                    end
                end
            end
            OP_REWIND: begin
                n_cursor = w_start;
            end
            OP_SETDIR: begin
                n_backward = i_new_direction;
                if (r_count != '0) begin
                    // Swap the cursor between its two end positions.
                    if (r_cursor == '1) begin
                        n_cursor = w_count_s;
                    end else if (r_cursor == w_count_s) begin
                        n_cursor = '1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    lwic_ram #(
        .WIDTH (HANDLE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_handle_in),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_cursor   <= '0;
            r_backward <= 1'b1;
        end else if (i_cmd.accept) begin
            r_count    <= n_count;
            r_cursor   <= n_cursor;
            r_backward <= n_backward;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_res_found  <= n_res_found;
            r_res_pidx   <= n_res_pidx;
            r_res_status <= n_res_status;
        end
        if (i_cmd.load) begin
            r_out_handle <= r_res_found ? w_rdata : '0;
            r_out_found  <= r_res_found;
            r_out_pidx   <= r_res_pidx;
            r_out_count  <= r_count;
            r_out_status <= r_res_status;
        end
    end

    assign o_handle_out  = r_out_handle;
    assign o_found       = r_out_found;
    assign o_push_index  = r_out_pidx;
    assign o_entry_count = r_out_count;
    assign o_status      = r_out_status;

endmodule

FILE: rtl/lwic_ctrl.sv
module lwic_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output lwic_pkg::t_cmd o_cmd
);
    import lwic_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_slot_free;

    // The output register can take a new word when empty or being drained.
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.load = w_slot_free;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import lwic_pkg::*;

    // The two op codes that the block leaves unused. Both must pass through
    // without touching the stack or the cursor.
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // Cycles without any word taken on either side before the run is declared hung.
    localparam int STALL_LIMIT     = 1000;
    // Length of the deliberate hold-off on the result side.
    localparam int HOLD_OFF_CYCLES = 60;
    // Pushes per phase: enough to fill the stack and then be refused twice.
    localparam int FILL_PUSHES     = DEPTH + 2;
    localparam int RANDOM_OPS      = 160;

    // One operation word as the driver presents it. A word marked drain_first
    // is held back until every outstanding result has come out.
    typedef struct {
        t_op                    op;
        logic [HANDLE_BITS-1:0] handle;
        logic                   direction;
        bit                     drain_first;
    } t_stack_op;

    // One result word, field for field as the output interface carries it.
    typedef struct packed {
        logic [HANDLE_BITS-1:0] handle_out;
        logic                   found;
        logic [ADDR_W-1:0]      push_index;
        logic [CNT_W-1:0]       entry_count;
        t_status                status;
    } t_stack_reply;

    logic i_clk;
    logic i_rst_n;

    lwic_in_if  in_bus ();
    lwic_out_if out_bus ();

    lifo_with_iterator_cursor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // Words still to be offered, and results that the predictor has worked out
    // but the block has not yet delivered.
    t_stack_op    pending_ops[$];
    t_stack_reply stack_replies[$];

    // Predictor state: its own copy of the stack, the fill level, the
    // iteration cursor and the direction.
    logic [HANDLE_BITS-1:0] stack_mem [DEPTH];
    int                     stack_fill;
    int                     iter_pos;
    bit                     iter_backward;

    // Idle rates for either side, in per cent, changed from phase to phase.
    int sender_gap_pct;
    int receiver_gap_pct;

    // The stimulus process asks for a hold-off by bumping hold_off_asked; the
    // receiver notices the difference and counts the stretch out on its own.
    int hold_off_asked;
    int hold_off_taken;
    int hold_off_left;

    bit in_word_taken;
    int stall_cycles;
    int failures;

    // Figures for the closing summary.
    int op_seen [8];
    int full_refusals;
    int empty_answers;
    int deepest_fill;

    // Starting end of the cursor: past the last entry when going backward,
    // before the first entry when going forward.
    function automatic int iter_home();
        return iter_backward ? stack_fill : -1;
    endfunction

    // Applies one operation to the predictor state and returns the result
    // word that the block is to produce for it.
    function automatic t_stack_reply apply_stack_op(input t_stack_op w);
        t_stack_reply r;
        r        = '0;
        r.status = ST_OK;
        case (w.op)
            OP_PUSH: begin
                if (stack_fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    stack_mem[stack_fill] = w.handle;
                    r.push_index          = ADDR_W'(stack_fill);
                    stack_fill++;
                    // Only the push that makes the stack non-empty moves the
                    // cursor; later pushes leave it where it is.
                    if (stack_fill == 1) begin
                        iter_pos = iter_home();
                    end
                end
            end
            OP_POP: begin
                // The cursor is deliberately left alone, so it may later point
                // at an entry that has been popped but still holds its value.
                if (stack_fill > 0) begin
                    stack_fill--;
                    r.handle_out = stack_mem[stack_fill];
                    r.found      = 1'b1;
                end else begin
                    r.status = ST_NONE;
                end
            end
            OP_CLEAR: begin
                stack_fill = 0;
                iter_pos   = 0;
            end
            OP_NEXT: begin
                if (stack_fill == 0) begin
                    r.status = ST_NONE;
                end else if (!iter_backward) begin
                    if (iter_pos < stack_fill - 1) begin
                        iter_pos++;
                        r.handle_out = stack_mem[iter_pos];
                        r.found      = 1'b1;
                    end else begin
                        r.status = ST_NONE;
                    end
                end else if (iter_pos > 0) begin
                    iter_pos--;
                    r.handle_out = stack_mem[iter_pos];
                    r.found      = 1'b1;
                end else begin
                    r.status = ST_NONE;
                end
            end
            OP_REWIND: begin
                iter_pos = iter_home();
            end
            OP_SETDIR: begin
                // A cursor sitting at one end swaps to the other end; anywhere
                // in between it stays put. On an empty stack only the
                // direction changes.
                iter_backward = w.direction;
                if (stack_fill != 0) begin
                    if (iter_pos == -1) begin
                        iter_pos = stack_fill;
                    end else if (iter_pos == stack_fill) begin
                        iter_pos = -1;
                    end
                end
            end
            default: begin
            end
        endcase
        r.entry_count = CNT_W'(stack_fill);
        return r;
    endfunction

    task automatic queue_op(input t_op op, input logic [HANDLE_BITS-1:0] handle,
                            input logic direction, input bit drain_first);
        t_stack_op w;
        w.op          = op;
        w.handle      = handle;
        w.direction   = direction;
        w.drain_first = drain_first;
        pending_ops.push_back(w);
    endtask

    // Mostly random handles, with the all-zero and all-one patterns mixed in.
    function automatic logic [HANDLE_BITS-1:0] random_handle();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8) begin
            return '0;
        end else if (roll < 16) begin
            return '1;
        end
        return HANDLE_BITS'($urandom());
    endfunction

    // Weighted so that pushes outrun pops and the stack spends time both in
    // the middle and against the full limit; clears are rare.
    function automatic t_op pick_random_op();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30) begin
            return OP_PUSH;
        end else if (roll < 50) begin
            return OP_POP;
        end else if (roll < 75) begin
            return OP_NEXT;
        end else if (roll < 83) begin
            return OP_REWIND;
        end else if (roll < 93) begin
            return OP_SETDIR;
        end else if (roll < 95) begin
            return OP_CLEAR;
        end else if (roll < 98) begin
            return t_op'(OP_SPARE_6);
        end
        return t_op'(OP_SPARE_7);
    endfunction

    // Blocks until every queued word has been taken and every result checked.
    task automatic wait_for_drain();
        while (pending_ops.size() != 0 || in_bus.valid || stack_replies.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // One random phase: clear, fill the stack past its limit, then a stretch
    // of random operations. The hold-off, where asked, lands during the fill
    // so that the block backs up while the sender keeps offering words.
    task automatic run_phase(input int sender_pct, input int receiver_pct,
                             input bit hold_off);
        sender_gap_pct   = sender_pct;
        receiver_gap_pct = receiver_pct;
        queue_op(OP_CLEAR, random_handle(), 1'($urandom_range(1)), 1'b1);
        for (int i = 0; i < FILL_PUSHES; i++) begin
            queue_op(OP_PUSH, random_handle(), 1'($urandom_range(1)), 1'b0);
        end
        for (int i = 0; i < RANDOM_OPS; i++) begin
            queue_op(pick_random_op(), random_handle(), 1'($urandom_range(1)),
                     $urandom_range(99) < 2);
        end
        if (hold_off) begin
            @(posedge i_clk);
            hold_off_asked++;
        end
        wait_for_drain();
    endtask

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // Driver: a new word goes out at the falling edge once the previous one
    // has been taken, or when nothing is on offer. A word that has gone out
    // stays put, valid held high, until the block takes it.
    always @(negedge i_clk) begin
        t_stack_op w;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!in_bus.valid || in_word_taken) begin
            if (pending_ops.size() != 0
                    && !(pending_ops[0].drain_first && stack_replies.size() != 0)
                    && $urandom_range(99) >= sender_gap_pct) begin
                w = pending_ops.pop_front();
                in_bus.op            <= w.op;
                in_bus.handle_in     <= w.handle;
                in_bus.new_direction <= w.direction;
                in_bus.valid         <= 1'b1;
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, or a long hold-off when one is asked.
    always @(negedge i_clk) begin
        if (hold_off_taken != hold_off_asked) begin
            hold_off_taken <= hold_off_asked;
            hold_off_left  <= HOLD_OFF_CYCLES;
            out_bus.ready  <= 1'b0;
        end else if (hold_off_left != 0) begin
            hold_off_left <= hold_off_left - 1;
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= ($urandom_range(99) >= receiver_gap_pct);
        end
    end

    // Monitor: at each rising edge, the result word on the output is checked
    // against the oldest prediction first, and only then is a word taken on
    // the input fed through the predictor, so that a result can never be
    // matched against a prediction made in the same cycle.
    always @(posedge i_clk) begin
        t_stack_op    w;
        t_stack_reply want;
        t_stack_reply got;
        in_word_taken <= in_bus.valid && in_bus.ready;
        if (i_rst_n) begin
            if (out_bus.valid && out_bus.ready) begin
                got.handle_out  = out_bus.handle_out;
                got.found       = out_bus.found;
                got.push_index  = out_bus.push_index;
                got.entry_count = out_bus.entry_count;
                got.status      = out_bus.status;
                if (stack_replies.size() == 0) begin
                    $error("result word arrived with nothing outstanding");
                    failures++;
                end else begin
                    want = stack_replies.pop_front();
                    if (got.handle_out !== want.handle_out) begin
                        $error("handle_out: expected %h, got %h",
                               want.handle_out, got.handle_out);
                        failures++;
                    end
                    if (got.found !== want.found) begin
                        $error("found: expected %b, got %b", want.found, got.found);
                        failures++;
                    end
                    if (got.push_index !== want.push_index) begin
                        $error("push_index: expected %0d, got %0d",
                               want.push_index, got.push_index);
                        failures++;
                    end
                    if (got.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, got.entry_count);
                        failures++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        failures++;
                    end
                end
            end
            if (in_bus.valid && in_bus.ready) begin
                w.op          = in_bus.op;
                w.handle      = in_bus.handle_in;
                w.direction   = in_bus.new_direction;
                w.drain_first = 1'b0;
                want          = apply_stack_op(w);
                stack_replies.push_back(want);
                op_seen[3'(w.op)]++;
                if (want.status == ST_FULL) begin
                    full_refusals++;
                end
                if (want.status == ST_NONE) begin
                    empty_answers++;
                end
                if (int'(want.entry_count) > deepest_fill) begin
                    deepest_fill = int'(want.entry_count);
                end
            end
        end
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Watchdog: a run that stops moving words for too long has hung.
    always @(posedge i_clk) begin
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        // Every input of the block has a known value from the first instant.
        i_rst_n              = 1'b0;
        in_bus.valid         = 1'b0;
        in_bus.op            = OP_PUSH;
        in_bus.handle_in     = '0;
        in_bus.new_direction = 1'b0;
        out_bus.ready        = 1'b0;
        stack_fill           = 0;
        iter_pos             = 0;
        iter_backward        = 1'b1;
        sender_gap_pct       = 14;
        receiver_gap_pct     = 61;
        hold_off_asked       = 0;
        hold_off_taken       = 0;
        hold_off_left        = 0;
        in_word_taken        = 1'b0;
        stall_cycles         = 0;
        failures             = 0;
        full_refusals        = 0;
        empty_answers        = 0;
        deepest_fill         = 0;
        foreach (op_seen[i]) begin
            op_seen[i] = 0;
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening. Straight out of reset the stack is empty and the
        // direction is backward.
        queue_op(OP_POP,    32'h1234_5678, 1'b1, 1'b0);  // pop on an empty stack
        queue_op(OP_NEXT,   32'h0,         1'b0, 1'b0);  // next on an empty stack
        queue_op(OP_SETDIR, 32'h0,         1'b0, 1'b0);  // direction only, no cursor move
        queue_op(OP_SETDIR, 32'h0,         1'b1, 1'b0);
        queue_op(OP_PUSH,   32'h0000_0000, 1'b0, 1'b0);  // first push places the cursor
        queue_op(OP_PUSH,   32'hFFFF_FFFF, 1'b1, 1'b0);
        queue_op(OP_PUSH,   32'hA5A5_A5A5, 1'b0, 1'b0);
        queue_op(OP_NEXT,   32'h0,         1'b0, 1'b0);  // walks down from the first push
        queue_op(OP_NEXT,   32'h0,         1'b1, 1'b0);  // runs off the bottom
        queue_op(OP_REWIND, 32'h0,         1'b0, 1'b0);
        queue_op(OP_NEXT,   32'h0,         1'b0, 1'b0);
        queue_op(OP_SETDIR, 32'hFFFF_FFFF, 1'b0, 1'b0);  // cursor mid-stack stays put
        queue_op(OP_NEXT,   32'h0,         1'b0, 1'b0);  // already at the top going forward
        queue_op(OP_REWIND, 32'h0,         1'b1, 1'b0);
        queue_op(OP_NEXT,   32'h0,         1'b0, 1'b0);
        queue_op(OP_REWIND, 32'h0,         1'b0, 1'b0);
        queue_op(OP_SETDIR, 32'h0,         1'b1, 1'b0);  // cursor at an end swaps ends
        queue_op(OP_NEXT,   32'h0,         1'b0, 1'b0);
        queue_op(OP_POP,    32'h0,         1'b0, 1'b0);
        queue_op(OP_POP,    32'h0,         1'b1, 1'b0);
        queue_op(OP_NEXT,   32'h0,         1'b0, 1'b0);  // reaches an entry already popped
        queue_op(t_op'(OP_SPARE_6), 32'hDEAD_BEEF, 1'b1, 1'b0);
        queue_op(t_op'(OP_SPARE_7), 32'h5A5A_5A5A, 1'b0, 1'b0);
        queue_op(OP_CLEAR,  32'h0,         1'b1, 1'b0);
        queue_op(OP_POP,    32'h0,         1'b0, 1'b0);  // nothing left after the clear
        wait_for_drain();

        // Random phases with the idling swapped between the two sides, then
        // none at all; the last one also carries the long receiver hold-off.
        run_phase(14, 61, 1'b0);
        run_phase(61, 14, 1'b0);
        run_phase(0, 0, 1'b1);

        wait_for_drain();
        repeat (8) @(posedge i_clk);

        $display("Covered %0d push, %0d pop, %0d clear, %0d next, %0d rewind, %0d direction",
                 op_seen[OP_PUSH], op_seen[OP_POP], op_seen[OP_CLEAR], op_seen[OP_NEXT],
                 op_seen[OP_REWIND], op_seen[OP_SETDIR]);
        $display("and %0d unused-code words; %0d full refusals, %0d empty answers, depth %0d.",
                 op_seen[OP_SPARE_6] + op_seen[OP_SPARE_7], full_refusals, empty_answers,
                 deepest_fill);
        if (failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/lwic_pkg.sv
rtl/lwic_in_if.sv
rtl/lwic_out_if.sv
rtl/lwic_ram.sv
rtl/lwic_dp.sv
rtl/lwic_ctrl.sv
rtl/lifo_with_iterator_cursor.sv
verif/testbench.sv
